[rtl/npt_pkg.sv]
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants for the next-prime search block.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 16;
    localparam int FIELD_WIDTH         = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TEST,
        ST_WAIT,
        ST_NEXT,
        ST_DONE
    } npt_state_t;

endpackage

[rtl/npt_rem.sv]
// ----------------------------------------------------------------------------
// npt_rem
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module npt_rem import npt_pkg::*; #(
    parameter int DVD_WIDTH = DEFAULT_VALUE_WIDTH,
    parameter int DIV_WIDTH = (DEFAULT_VALUE_WIDTH + 1) / 2 + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DVD_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [DIV_WIDTH-1:0] remainder
);

    localparam int CNT_WIDTH = $clog2(DVD_WIDTH + 1);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [CNT_WIDTH-1:0] cnt_reg,   cnt_next;
    logic [DVD_WIDTH-1:0] dvd_reg,   dvd_next;
    logic [DIV_WIDTH-1:0] div_reg,   div_next;
    logic [DIV_WIDTH-1:0] rem_reg,   rem_next;
    logic [DIV_WIDTH:0]   shifted;
    logic [DIV_WIDTH:0]   diff;

    assign shifted = {rem_reg, dvd_reg[DVD_WIDTH-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(DVD_WIDTH);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_WIDTH-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg}) begin
                rem_next = diff[DIV_WIDTH-1:0];
            end else begin
                rem_next = shifted[DIV_WIDTH-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[rtl/next_prime_trial_division_top.sv]
// Each candidate passes a check state, then a test state and a remainder run for each trial divisor.
// Divisors run from 2 up to the smallest factor of the candidate, or up to the square root for a
// prime, and none run for a candidate below two. The result is offered after the last one.
// Throughput: one transfer at a time; a new start value is taken only after the
// result transfer completes. The remainder unit sets the pace, one bit per cycle.
// Reset: synchronous, active low; the block returns to idle with no pending result.
// ----------------------------------------------------------------------------
// next_prime_trial_division_top
// Finds the smallest prime at or above a start value by trial division.
// ----------------------------------------------------------------------------
module next_prime_trial_division_top import npt_pkg::*; #(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FIELD_WIDTH-1:0] s_start_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FIELD_WIDTH-1:0] m_prime_found,
    output logic                   m_overflow
);

    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SW = 2 * DW;

    npt_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] cand_reg,  cand_next;
    logic [DW-1:0]          d_reg,     d_next;
    logic [SW-1:0]          sq_reg,    sq_next;
    logic [FIELD_WIDTH-1:0] prime_reg, prime_next;
    logic                   ovf_reg,   ovf_next;
    logic                   div_start;
    logic                   div_done;
    logic [DW-1:0]          div_rem;

    npt_rem #(
        .DVD_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH (DW)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (cand_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        cand_next  = cand_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        prime_next = prime_reg;
        ovf_next   = ovf_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cand_next  = VALUE_WIDTH'(s_start_value);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                d_next  = DW'(2);
                sq_next = SW'(4);
                if (cand_reg < VALUE_WIDTH'(2)) begin
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (sq_reg > SW'(cand_reg)) begin
                    prime_next = FIELD_WIDTH'(cand_reg);
                    ovf_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        state_next = ST_NEXT;
                    end else begin
                        d_next     = d_reg + 1'b1;
                        sq_next    = sq_reg + SW'({d_reg, 1'b1});
                        state_next = ST_TEST;
                    end
                end
            end
            ST_NEXT: begin
                if (&cand_reg) begin
                    prime_next = '0;
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cand_next  = cand_reg + 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg  <= cand_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
        ovf_reg   <= ovf_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_DONE);
    assign m_prime_found = prime_reg;
    assign m_overflow    = ovf_reg;

endmodule

[rtl/npt_checker.sv]
// ----------------------------------------------------------------------------
// npt_checker
// Port-level checks for the next-prime search block, bound to the top level.
// ----------------------------------------------------------------------------
module npt_checker import npt_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [FIELD_WIDTH-1:0] m_prime_found,
    input logic                   m_overflow
);

    // A held result must not change until its transfer completes.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime_found) && $stable(m_overflow))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    a_overflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_prime_found == '0)
        else $error("overflow result is not zero");

    // Every prime other than two is odd, also after truncation to the field.
    a_prime_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overflow |-> m_prime_found[0] || m_prime_found == FIELD_WIDTH'(2))
        else $error("reported prime is even and not two");

endmodule

bind next_prime_trial_division_top npt_checker u_npt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_prime_found (m_prime_found),
    .m_overflow    (m_overflow)
);
